// ===== hw/rtl/utf8v_pkg.sv =====
// Package for the UTF-8 stream validator: constants and the code point range check.
`default_nettype none

package utf8v_pkg;

	localparam int unsigned CpWidth = 21;

	localparam logic [7:0]         LeadC0      = 8'hc0;
	localparam logic [7:0]         LeadC1      = 8'hc1;
	localparam logic [7:0]         ContTag     = 8'h80;
	localparam logic [7:0]         ContMask    = 8'h3f;
	localparam logic [CpWidth-1:0] Min3Byte    = 21'h000800;
	localparam logic [CpWidth-1:0] SurrLo      = 21'h00d800;
	localparam logic [CpWidth-1:0] SurrHi      = 21'h00dfff;
	localparam logic [CpWidth-1:0] NonCharLo   = 21'h00fffe;
	localparam logic [CpWidth-1:0] NonCharHi   = 21'h00ffff;
	localparam logic [CpWidth-1:0] Min4Byte    = 21'h010000;
	localparam logic [CpWidth-1:0] MaxCodePt   = 21'h10ffff;

	localparam logic [2:0] Len1 = 3'd1;
	localparam logic [2:0] Len2 = 3'd2;
	localparam logic [2:0] Len3 = 3'd3;
	localparam logic [2:0] Len4 = 3'd4;

	function automatic logic cp_ok(input logic [2:0] len, input logic [CpWidth-1:0] cp);
		logic ok;
		ok = 1'b1;
		case (len)
			Len3: begin
				if (cp < Min3Byte)
					ok = 1'b0;
				else if (cp inside {[SurrLo:SurrHi]})
					ok = 1'b0;
				else if (cp inside {[NonCharLo:NonCharHi]})
					ok = 1'b0;
			end
			Len4: begin
				if (cp < Min4Byte || cp > MaxCodePt)
					ok = 1'b0;
			end
			default: begin
				ok = 1'b1;
			end
		endcase
		return ok;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_stream_validator.sv =====
// UTF-8 stream validator: input register, per-byte decode and check, result register.
//
//  channel  valid         stall         word
//  byte     byte_valid    byte_stall    data_byte[7:0], last_byte
//  result   result_valid  result_stall  error_seen, verdict_ready, buffer_valid
//
// One byte per cycle unless the result side stalls; each byte yields one result word,
// through the input register and then the result register. The decode state (pending
// count, length, code point, error) updates when the input register moves into the
// result register. Reset clears both stages and puts the decode state at its idle
// values. A stalled result word holds; the input register still takes one more byte.
`default_nettype none

module utf8_stream_validator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic            error_seen,
	output logic            verdict_ready,
	output logic            buffer_valid
);

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic vld_s2;
	logic err_s2;
	logic vrd_s2;
	logic bok_s2;

	logic [1:0]                       pend_q;
	logic [2:0]                       len_q;
	logic [utf8v_pkg::CpWidth-1:0]    cp_q;
	logic                             err_q;

	logic [1:0]                       pend_n;
	logic [2:0]                       len_n;
	logic [utf8v_pkg::CpWidth-1:0]    cp_n;
	logic                             err_n;
	logic                             chk;

	logic ld_s1;
	logic ld_s2;

	assign ld_s2      = vld_s1 && (!vld_s2 || !result_stall);
	assign ld_s1      = !vld_s1 || ld_s2;
	assign byte_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld_s1) begin
			vld_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && byte_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		pend_n = pend_q;
		len_n  = len_q;
		cp_n   = cp_q;
		err_n  = err_q;
		chk    = 1'b0;
		if (!err_q) begin
			if (pend_q == 2'd0) begin
				if (!byte_s1[7]) begin
					len_n = utf8v_pkg::Len1;
					chk   = 1'b1;
				end else if (!byte_s1[6]) begin
					err_n = 1'b1;
				end else if (byte_s1 == utf8v_pkg::LeadC0 || byte_s1 == utf8v_pkg::LeadC1) begin
					err_n = 1'b1;
				end else if (!byte_s1[5]) begin
					len_n  = utf8v_pkg::Len2;
					pend_n = 2'd1;
					cp_n   = {16'd0, byte_s1[4:0]};
				end else if (!byte_s1[4]) begin
					len_n  = utf8v_pkg::Len3;
					pend_n = 2'd2;
					cp_n   = {17'd0, byte_s1[3:0]};
				end else if (!byte_s1[3]) begin
					len_n  = utf8v_pkg::Len4;
					pend_n = 2'd3;
					cp_n   = {18'd0, byte_s1[2:0]};
				end else begin
					err_n = 1'b1;
				end
			end else begin
				if ((byte_s1 & ~utf8v_pkg::ContMask) != utf8v_pkg::ContTag) begin
					err_n = 1'b1;
				end else begin
					cp_n   = {cp_q[utf8v_pkg::CpWidth-7:0], byte_s1[5:0]};
					pend_n = pend_q - 2'd1;
					chk    = (pend_q == 2'd1);
				end
			end
			if (chk) begin
				if (!utf8v_pkg::cp_ok(len_n, cp_n))
					err_n = 1'b1;
				else
					cp_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			len_q  <= utf8v_pkg::Len1;
			cp_q   <= '0;
			err_q  <= 1'b0;
		end else if (ld_s2) begin
			if (last_s1) begin
				pend_q <= 2'd0;
				len_q  <= utf8v_pkg::Len1;
				cp_q   <= '0;
				err_q  <= 1'b0;
			end else begin
				pend_q <= pend_n;
				len_q  <= len_n;
				cp_q   <= cp_n;
				err_q  <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || !result_stall) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			err_s2 <= err_n;
			vrd_s2 <= last_s1;
			bok_s2 <= last_s1 && !err_n && (pend_n == 2'd0);
		end
	end

	assign result_valid  = vld_s2;
	assign error_seen    = err_s2;
	assign verdict_ready = vrd_s2;
	assign buffer_valid  = bok_s2;

	a_ok_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && buffer_valid) |-> (verdict_ready && !error_seen))
		else $error("valid verdict with error set");

	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_s2 && last_s1) |=> (pend_q == 2'd0 && !err_q && len_q == utf8v_pkg::Len1))
		else $error("decode state not cleared after last byte");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q && !(ld_s2 && last_s1)) |=> err_q)
		else $error("error flag dropped inside a buffer");

	a_pend_len: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd3) |-> (len_q == utf8v_pkg::Len4))
		else $error("three pending bytes without a four-byte lead");

endmodule

`default_nettype wire

// ===== tb/utf8_stream_validator_tb.sv =====
// UTF-8 validator testbench: directed and random byte buffers checked against a software decoder.
`default_nettype none

module utf8_stream_validator_tb;

	localparam int RandomBytes    = 1150;
	localparam int IdleLimit      = 2000;
	localparam int DrainCycles    = 16;
	localparam int PressureAt     = 400;
	localparam int PressureCycles = 300;

	typedef struct packed {
		logic [7:0] value;
		logic       fin;
	} byte_word_t;

	typedef struct packed {
		logic err;
		logic done;
		logic ok;
	} verdict_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       byte_valid   = 1'b0;
	logic [7:0] data_byte    = 8'h00;
	logic       last_byte    = 1'b0;
	logic       result_stall = 1'b0;
	logic       byte_stall;
	logic       result_valid;
	logic       error_seen;
	logic       verdict_ready;
	logic       buffer_valid;

	byte_word_t  byte_q[$];
	logic  [7:0] frame_q[$];
	verdict_t    verdict_q[$];

	// decoder state
	logic [1:0]                    cont_left = 2'd0;
	logic [2:0]                    seq_len   = utf8v_pkg::Len1;
	logic [utf8v_pkg::CpWidth-1:0] cp_acc    = '0;
	logic                          bad_seen  = 1'b0;

	int bytes_sent    = 0;
	int results_seen  = 0;
	int buffers_done  = 0;
	int buffers_clean = 0;
	int error_words   = 0;
	int mismatches    = 0;
	int byte_gap      = 0;
	int stall_left    = 0;
	int idle_cycles   = 0;
	bit squeezed      = 1'b0;

	byte_word_t nxt;
	verdict_t   got;
	verdict_t   want;

	utf8_stream_validator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.error_seen    (error_seen),
		.verdict_ready (verdict_ready),
		.buffer_valid  (buffer_valid)
	);

	always #10 clk = ~clk;

	function automatic verdict_t decode_utf8_byte(input logic [7:0] b, input logic fin);
		verdict_t v;
		if (!bad_seen) begin
			if (cont_left == 2'd0) begin
				casez (b)
					8'b0???????: begin
						seq_len = utf8v_pkg::Len1;
					end
					8'b10??????: begin
						bad_seen = 1'b1;
					end
					8'b110?????: begin
						if (b == utf8v_pkg::LeadC0 || b == utf8v_pkg::LeadC1) begin
							bad_seen = 1'b1;
						end else begin
							seq_len   = utf8v_pkg::Len2;
							cont_left = 2'd1;
							cp_acc    = utf8v_pkg::CpWidth'(b[4:0]);
						end
					end
					8'b1110????: begin
						seq_len   = utf8v_pkg::Len3;
						cont_left = 2'd2;
						cp_acc    = utf8v_pkg::CpWidth'(b[3:0]);
					end
					8'b11110???: begin
						seq_len   = utf8v_pkg::Len4;
						cont_left = 2'd3;
						cp_acc    = utf8v_pkg::CpWidth'(b[2:0]);
					end
					default: begin
						bad_seen = 1'b1;
					end
				endcase
			end else if ((b & 8'hc0) != utf8v_pkg::ContTag) begin
				bad_seen = 1'b1;
			end else begin
				cp_acc    = {cp_acc[utf8v_pkg::CpWidth-7:0], b[5:0]};
				cont_left = cont_left - 2'd1;
			end
			if (!bad_seen && cont_left == 2'd0) begin
				if (seq_len == utf8v_pkg::Len3 && (cp_acc < utf8v_pkg::Min3Byte ||
						(cp_acc >= utf8v_pkg::SurrLo && cp_acc <= utf8v_pkg::SurrHi) ||
						(cp_acc >= utf8v_pkg::NonCharLo && cp_acc <= utf8v_pkg::NonCharHi)))
					bad_seen = 1'b1;
				else if (seq_len == utf8v_pkg::Len4 && (cp_acc < utf8v_pkg::Min4Byte ||
						cp_acc > utf8v_pkg::MaxCodePt))
					bad_seen = 1'b1;
				else
					cp_acc = '0;
			end
		end
		v.err  = bad_seen;
		v.done = fin;
		v.ok   = fin && !bad_seen && cont_left == 2'd0;
		if (fin) begin
			cont_left = 2'd0;
			seq_len   = utf8v_pkg::Len1;
			cp_acc    = '0;
			bad_seen  = 1'b0;
		end
		return v;
	endfunction

	function automatic int pick_gap(input int count);
		int r;
		if ((count / 150) % 3 == 1)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [utf8v_pkg::CpWidth-1:0] pick_cp3();
		case ($urandom_range(0, 13))
			0: return 21'h0007ff;
			1: return 21'h000800;
			2: return 21'h00d7ff;
			3: return 21'h00d800;
			4: return 21'h00dfff;
			5: return 21'h00e000;
			6: return 21'h00fffd;
			7: return 21'h00fffe;
			8: return 21'h00ffff;
			9: return 21'h000000;
			default: return utf8v_pkg::CpWidth'($urandom_range(21'h000800, 21'h00ffff));
		endcase
	endfunction

	function automatic logic [utf8v_pkg::CpWidth-1:0] pick_cp4();
		case ($urandom_range(0, 11))
			0: return 21'h00ffff;
			1: return 21'h010000;
			2: return 21'h10ffff;
			3: return 21'h110000;
			4: return 21'h1fffff;
			5: return 21'h000000;
			default: return utf8v_pkg::CpWidth'($urandom_range(21'h010000, 21'h10ffff));
		endcase
	endfunction

	task automatic add_cp(input logic [utf8v_pkg::CpWidth-1:0] cp, input int len,
			input int keep);
		logic [7:0] enc [4];
		case (len)
			1: begin
				enc[0] = {1'b0, cp[6:0]};
			end
			2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			default: begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++)
			frame_q.push_back(enc[i]);
	endtask

	task automatic flush_frame();
		logic [7:0] b;
		while (frame_q.size() != 0) begin
			b = frame_q.pop_front();
			byte_q.push_back({b, frame_q.size() == 0});
		end
	endtask

	task automatic put_frame(input logic [63:0] bytes, input int n);
		for (int i = n - 1; i >= 0; i--)
			frame_q.push_back(bytes[8*i +: 8]);
		flush_frame();
	endtask

	task automatic check_field(input string name, input logic exp_bit, input logic act_bit);
		if (exp_bit !== act_bit) begin
			mismatches++;
			$display("%0t: %s expected %0b actual %0b", $time, name, exp_bit, act_bit);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			data_byte  <= 8'h00;
			last_byte  <= 1'b0;
		end else begin
			if (byte_valid && !byte_stall) begin
				verdict_q.push_back(decode_utf8_byte(data_byte, last_byte));
				bytes_sent++;
				byte_gap = pick_gap(bytes_sent);
			end
			if (byte_valid && byte_stall) begin
				// hold the stalled word
			end else if (byte_gap != 0) begin
				byte_gap--;
				byte_valid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				nxt = byte_q.pop_front();
				byte_valid <= 1'b1;
				data_byte  <= nxt.value;
				last_byte  <= nxt.fin;
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				got = {error_seen, verdict_ready, buffer_valid};
				results_seen++;
				if (verdict_q.size() == 0) begin
					mismatches++;
					$display("%0t: expected no word, actual %b", $time, got);
				end else begin
					want = verdict_q.pop_front();
					check_field("error_seen", want.err, got.err);
					check_field("verdict_ready", want.done, got.done);
					check_field("buffer_valid", want.ok, got.ok);
					if (want.done)
						buffers_done++;
					if (want.ok)
						buffers_clean++;
					if (want.err)
						error_words++;
				end
			end
			// hold off for a long stretch once so the input side backs up
			if (!squeezed && results_seen >= PressureAt) begin
				stall_left = PressureCycles;
				squeezed   = 1'b1;
			end
			if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				stall_left = pick_gap(results_seen + 75);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t: no word moved for %0d cycles", $time, IdleLimit);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int kind;
		int len;
		int first_random;
		logic [utf8v_pkg::CpWidth-1:0] cp;

		put_frame(64'h007f_c280_f48f_bfbf, 8);
		put_frame(64'h80, 1);
		put_frame(64'hc0_41c3, 3);
		put_frame(64'hc3_41, 2);
		put_frame(64'he0_8080, 3);
		put_frame(64'hed_a080, 3);
		put_frame(64'hef_bfbe, 3);
		put_frame(64'hf490_8080, 4);
		put_frame(64'he2_82, 2);
		first_random = byte_q.size();

		while (byte_q.size() < first_random + RandomBytes) begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				kind = $urandom_range(0, 99);
				if (kind < 30) begin
					add_cp(utf8v_pkg::CpWidth'($urandom_range(0, 127)), 1, 1);
				end else if (kind < 45) begin
					if ($urandom_range(0, 19) == 0)
						cp = utf8v_pkg::CpWidth'($urandom_range(0, 127));
					else
						cp = utf8v_pkg::CpWidth'($urandom_range(128, 2047));
					add_cp(cp, 2, 2);
				end else if (kind < 65) begin
					add_cp(pick_cp3(), 3, 3);
				end else if (kind < 80) begin
					add_cp(pick_cp4(), 4, 4);
				end else if (kind < 92) begin
					frame_q.push_back(8'($urandom_range(0, 255)));
				end else begin
					len = $urandom_range(2, 4);
					add_cp(utf8v_pkg::CpWidth'($urandom_range(0, 21'h10ffff)), len,
						$urandom_range(1, len - 1));
				end
			end
			flush_frame();
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || byte_valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("checked %0d bytes in %0d buffers, %0d judged valid", bytes_sent,
			buffers_done, buffers_clean);
		$display("%0d result words, %0d with the error flag up, %0d mismatches", results_seen,
			error_words, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
